>>> src/gfla_pkg.sv
// Shared definitions for the GF(2^8) log/antilog arithmetic unit.
// Holds command and register codes, reset values and the shift-and-xor multiply.
// No dependencies.
package gfla_pkg;

   localparam logic [1:0] CMD_BUILD  = 2'd0;
   localparam logic [1:0] CMD_TMUL   = 2'd1;
   localparam logic [1:0] CMD_TINV   = 2'd2;
   localparam logic [1:0] CMD_DMUL   = 2'd3;

   localparam logic [1:0] CSR_IDX_POLY = 2'd0;
   localparam logic [1:0] CSR_IDX_GEN  = 2'd1;

   localparam logic [7:0] POLY_RESET = 8'h1B;
   localparam logic [7:0] GEN_RESET  = 8'd3;

   // Multiplicative group order and the last index of the table walk.
   localparam logic [8:0] GROUP_ORDER = 9'd255;
   localparam logic [7:0] WALK_LAST   = 8'd254;

   typedef logic [7:0] elem_type;

   // Carry-less multiply with reduction; eight narrow dependent steps.
   function automatic elem_type field_mul(elem_type a, elem_type b, elem_type poly);
      elem_type acc;
      elem_type x;
      acc = '0;
      x   = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         if (x[7]) begin
            x = {x[6:0], 1'b0} ^ poly;
         end else begin
            x = {x[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

>>> src/gfla_log_mem.sv
// Log store: 256 x 8 synchronous memory, two registered read ports, one write port.
// Per-entry valid bits make entries never written read as zero.
// Depends on gfla_pkg.
module gfla_log_mem
   import gfla_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     rd_en,
   input  elem_type rd_addr_a,
   input  elem_type rd_addr_b,
   output elem_type rd_data_a,
   output elem_type rd_data_b,
   input  logic     wr_en,
   input  elem_type wr_addr,
   input  elem_type wr_data
);

   elem_type     mem [0:255];
   logic [255:0] vld_ff;
   logic [255:0] vld_in;
   elem_type     rda_ff;
   elem_type     rdb_ff;
   logic         va_ff;
   logic         vb_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rda_ff <= mem[rd_addr_a];
         rdb_ff <= mem[rd_addr_b];
         va_ff  <= vld_ff[rd_addr_a];
         vb_ff  <= vld_ff[rd_addr_b];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rd_data_a = va_ff ? rda_ff : '0;
   assign rd_data_b = vb_ff ? rdb_ff : '0;

endmodule

>>> src/gfla_alog_mem.sv
// Antilog store: 255 x 8 synchronous memory, one registered read port, one write port.
// A build writes every entry before any read, so one fill flag replaces valid bits.
// Depends on gfla_pkg.
module gfla_alog_mem
   import gfla_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     rd_en,
   input  elem_type rd_addr,
   output elem_type rd_data,
   input  logic     wr_en,
   input  elem_type wr_addr,
   input  elem_type wr_data
);

   elem_type mem [0:254];
   elem_type rd_ff;
   logic     filled_ff;
   logic     filled_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign filled_in = filled_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   assign rd_data = filled_ff ? rd_ff : '0;

endmodule

>>> src/gf256_log_antilog_arith.sv
// Top level of the GF(2^8) arithmetic unit: command sequencer, configuration registers,
// table walk and output register. Uses gfla_pkg, gfla_log_mem and gfla_alog_mem.
//
//   channel   ports                                         handshake
//   --------  --------------------------------------------  -----------------------------
//   request   req_command, req_operand_a, req_operand_b      start high while busy low
//   response  rsp_result                                     rsp_valid, one cycle, no stall
//   config    csr_index, csr_data                            csr_valid and csr_ready
//
// A direct multiply is accepted and its product appears on the next cycle, with the block
// free to accept again at once.
// A table multiply or inverse passes the log read, the antilog read and the output
// register in that order; busy is high through the lookup and finish states.
// A build clears log entry zero and then takes 255 walk steps, each step one write to
// each store, and then shows its zero item on the response port.
// Reset clears the configuration registers to their defaults, the log valid bits and the
// antilog fill flag, so every table lookup returns zero until a build is done.
// The receiver cannot stall: each item is shown for exactly one cycle.
module gf256_log_antilog_arith
   import gfla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_command,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   // response channel
   output logic       rsp_valid,
   output logic [7:0] rsp_result,
   // configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_FINISH = 3'd2;
   localparam logic [2:0] ST_CLEAR0 = 3'd3;
   localparam logic [2:0] ST_WALK   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   elem_type   poly_ff;
   elem_type   poly_in;
   elem_type   gen_ff;
   elem_type   gen_in;

   logic [1:0] cmd_ff;
   logic [1:0] cmd_in;
   logic       zero_ff;
   logic       zero_in;

   // Walk position and current power of the generator.
   elem_type   cnt_ff;
   elem_type   cnt_in;
   elem_type   pow_ff;
   elem_type   pow_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   elem_type   rsp_result_ff;
   elem_type   rsp_result_in;

   logic       accept;
   logic       csr_wr;

   elem_type   log_a;
   elem_type   log_b;
   logic       log_wr_en;
   elem_type   log_wr_addr;
   elem_type   log_wr_data;

   logic [8:0] idx_raw;
   elem_type   alog_idx;
   elem_type   alog_data;
   logic       alog_rd_en;
   logic       alog_wr_en;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // Configuration registers; indexes beyond the list are dropped.
   always_comb begin
      poly_in = poly_ff;
      gen_in  = gen_ff;
      if (csr_wr && (csr_index == CSR_IDX_POLY)) begin
         poly_in = csr_data;
      end
      if (csr_wr && (csr_index == CSR_IDX_GEN)) begin
         gen_in = csr_data;
      end
   end

   // Log store: both operands are read at the accept edge. During a build it is written
   // first at entry zero and then once per walk step at the current power.
   assign log_wr_en   = (state_ff == ST_CLEAR0) || (state_ff == ST_WALK);
   assign log_wr_addr = (state_ff == ST_CLEAR0) ? '0 : pow_ff;
   assign log_wr_data = (state_ff == ST_CLEAR0) ? '0 : cnt_ff;

   gfla_log_mem u_log (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_operand_a),
      .rd_addr_b (req_operand_b),
      .rd_data_a (log_a),
      .rd_data_b (log_b),
      .wr_en     (log_wr_en),
      .wr_addr   (log_wr_addr),
      .wr_data   (log_wr_data)
   );

   // Antilog index: sum of logs for a multiply, group order minus log for an inverse.
   // Both stay below twice the group order, so one conditional subtract reduces them.
   always_comb begin
      if (cmd_ff == CMD_TINV) begin
         idx_raw = GROUP_ORDER - {1'b0, log_a};
      end else begin
         idx_raw = {1'b0, log_a} + {1'b0, log_b};
      end
      if (idx_raw >= GROUP_ORDER) begin
         alog_idx = elem_type'(idx_raw - GROUP_ORDER);
      end else begin
         alog_idx = idx_raw[7:0];
      end
   end

   assign alog_rd_en = (state_ff == ST_LOOKUP);
   assign alog_wr_en = (state_ff == ST_WALK);

   gfla_alog_mem u_alog (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (alog_rd_en),
      .rd_addr (alog_idx),
      .rd_data (alog_data),
      .wr_en   (alog_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (pow_ff)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      pow_in   = pow_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               zero_in = (req_operand_a == '0) ||
                         ((req_command == CMD_TMUL) && (req_operand_b == '0));
               unique case (req_command)
                  CMD_BUILD: begin
                     state_in = ST_CLEAR0;
                     cnt_in   = '0;
                     pow_in   = 8'd1;
                  end
                  CMD_TMUL, CMD_TINV: begin
                     state_in = ST_LOOKUP;
                  end
                  CMD_DMUL: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR0: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            pow_in = field_mul(pow_ff, gen_ff, poly_ff);
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == WALK_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: a direct product, a table result, or zero after a build.
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_result_in = '0;
      priority if (accept && (req_command == CMD_DMUL)) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = field_mul(req_operand_a, req_operand_b, poly_ff);
      end else if (state_ff == ST_FINISH) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = zero_ff ? '0 : alog_data;
      end else if ((state_ff == ST_WALK) && (cnt_ff == WALK_LAST)) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = '0;
      end else begin
         rsp_valid_in  = 1'b0;
         rsp_result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         poly_ff      <= POLY_RESET;
         gen_ff       <= GEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poly_ff      <= poly_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      zero_ff       <= zero_in;
      cnt_ff        <= cnt_in;
      pow_ff        <= pow_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef NO_ASSERTIONS
   // A table command delivers its item after the log read, the antilog read and the output register.
   a_table_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_command == CMD_TMUL) || (req_command == CMD_TINV)))
      |-> ##3 rsp_valid)
      else $error("table command item not delivered on time");

   // A direct multiply delivers its item on the next cycle.
   a_direct_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_DMUL)) |=> rsp_valid)
      else $error("direct multiply item not delivered on time");

   // A build sets the block busy, with no item shown, right after acceptance.
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_BUILD)) |=> (busy && !rsp_valid))
      else $error("build did not hold the block busy");

   // The walk never runs past the last antilog entry.
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff <= WALK_LAST))
      else $error("table walk ran past the last entry");
`endif

endmodule
